FILE: sv/uvs_pkg.sv
// uvs_pkg: shared types, constants and helpers of the uv sphere tessellator
// no dependencies; imported by uvs_sinq, uv_sphere_vertex_and_strip_index and the bench
package uvs_pkg;

  localparam int FRAC_BITS_DEF = 15;
  localparam logic [7:0] SEG_RESET = 8'd16;
  localparam logic REQ_VERTEX = 1'b0;
  localparam logic REQ_STRIP = 1'b1;

  localparam int DIV_STEPS = 33;
  localparam int SINQ_LAT = 22;
  localparam int NUM_DIV = 4;
  localparam int NUM_TAYLOR = 6;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE30 = 31'h4000_0000;

  localparam logic [7:0] TAYLOR_DIV [NUM_TAYLOR] = '{
    8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
  };
  localparam logic [29:0] TAYLOR_RECIP [NUM_TAYLOR] = '{
    30'((64'd1 << 32) / 64'd156), 30'((64'd1 << 32) / 64'd110),
    30'((64'd1 << 32) / 64'd72), 30'((64'd1 << 32) / 64'd42),
    30'((64'd1 << 32) / 64'd20), 30'((64'd1 << 32) / 64'd6)
  };

  typedef struct packed {
    logic [8:0]  r;
    logic [32:0] w;
  } div_t;

  typedef struct packed {
    logic        req_type;
    logic        err;
    logic [15:0] first;
    logic [15:0] second;
  } meta_t;

  typedef struct packed {
    meta_t       m;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [1:0]  ql;
    logic [1:0]  qo;
  } meta2_t;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [15:0] first_index;
    logic [15:0] second_index;
    logic        range_error;
  } res_t;

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [9:0] div_step(logic [8:0] r, logic b, logic [8:0] d);
    logic [9:0] rr;
    rr = {r, b};
    if (rr >= {1'b0, d}) begin
      return {1'b1, 9'(rr - {1'b0, d})};
    end else begin
      return {1'b0, rr[8:0]};
    end
  endfunction

endpackage

FILE: sv/uvs_sinq.sv
// uvs_sinq: pipelined quarter-wave sine, taylor series with reciprocal division
// depends on uvs_pkg
module uvs_sinq #(
  parameter int FRAC_BITS = uvs_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [30:0]          arg,
  output logic [FRAC_BITS:0]   mag
);
  import uvs_pkg::*;

  localparam int TS = 30 - FRAC_BITS;
  localparam logic [30:0] HALF = (31'd1 << TS) >> 1;

  logic [61:0] px;
  logic [30:0] x1_r;
  logic        sat1_r;
  logic [61:0] p2;
  logic [31:0] x2_r;
  logic [30:0] xs2_r;
  logic        sat2_r;

  logic [31:0] ya_r  [NUM_TAYLOR];
  logic [31:0] x2a_r [NUM_TAYLOR];
  logic [30:0] xa_r  [NUM_TAYLOR];
  logic        sata_r[NUM_TAYLOR];
  logic [29:0] qb_r  [NUM_TAYLOR];
  logic [31:0] yb_r  [NUM_TAYLOR];
  logic [31:0] x2b_r [NUM_TAYLOR];
  logic [30:0] xb_r  [NUM_TAYLOR];
  logic        satb_r[NUM_TAYLOR];
  logic [30:0] tc_r  [NUM_TAYLOR];
  logic [31:0] x2c_r [NUM_TAYLOR];
  logic [30:0] xc_r  [NUM_TAYLOR];
  logic        satc_r[NUM_TAYLOR];

  logic [61:0] pf;
  logic [31:0] sf_r;
  logic        satf_r;
  logic [30:0] smin;
  logic [31:0] sr;
  logic [FRAC_BITS:0] mag_r;

  assign px = 62'(arg) * 62'(HALF_PI_Q30);
  assign p2 = 62'(x1_r) * 62'(x1_r);

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= px[60:30];
      sat1_r <= arg[30];
      x2_r   <= p2[61:30];
      xs2_r  <= x1_r;
      sat2_r <= sat1_r;
    end
  end

  for (genvar i = 0; i < NUM_TAYLOR; i++) begin : g_it
    logic [31:0] x2_in;
    logic [30:0] t_in;
    logic [30:0] x_in;
    logic        sat_in;
    logic [62:0] pa;
    logic [61:0] pb;
    logic [31:0] qd;
    logic [31:0] rem;
    logic [30:0] qc;

    if (i == 0) begin : g_first
      assign x2_in  = x2_r;
      assign t_in   = ONE30;
      assign x_in   = xs2_r;
      assign sat_in = sat2_r;
    end else begin : g_next
      assign x2_in  = x2c_r[i-1];
      assign t_in   = tc_r[i-1];
      assign x_in   = xc_r[i-1];
      assign sat_in = satc_r[i-1];
    end

    assign pa  = 63'(x2_in) * 63'(t_in);
    assign pb  = 62'(ya_r[i]) * 62'(TAYLOR_RECIP[i]);
    assign qd  = 32'(38'(qb_r[i]) * 38'(TAYLOR_DIV[i]));
    assign rem = yb_r[i] - qd;
    assign qc  = {1'b0, qb_r[i]} + ((rem >= 32'(TAYLOR_DIV[i])) ? 31'd1 : 31'd0);

    always_ff @(posedge clk) begin
      if (en) begin
        ya_r[i]   <= pa[61:30];
        x2a_r[i]  <= x2_in;
        xa_r[i]   <= x_in;
        sata_r[i] <= sat_in;
        qb_r[i]   <= pb[61:32];
        yb_r[i]   <= ya_r[i];
        x2b_r[i]  <= x2a_r[i];
        xb_r[i]   <= xa_r[i];
        satb_r[i] <= sata_r[i];
        tc_r[i]   <= ONE30 - qc;
        x2c_r[i]  <= x2b_r[i];
        xc_r[i]   <= xb_r[i];
        satc_r[i] <= satb_r[i];
      end
    end
  end

  assign pf   = 62'(xc_r[NUM_TAYLOR-1]) * 62'(tc_r[NUM_TAYLOR-1]);
  assign smin = (sf_r > 32'(ONE30)) ? ONE30 : sf_r[30:0];
  assign sr   = 32'(smin) + 32'(HALF);

  always_ff @(posedge clk) begin
    if (en) begin
      sf_r   <= pf[61:30];
      satf_r <= satc_r[NUM_TAYLOR-1];
      if (satf_r) begin
        mag_r <= (FRAC_BITS+1)'(1) << FRAC_BITS;
      end else begin
        mag_r <= (FRAC_BITS+1)'(sr >> TS);
      end
    end
  end

  assign mag = mag_r;

endmodule

FILE: sv/uv_sphere_vertex_and_strip_index.sv
// uv_sphere_vertex_and_strip_index: top level of the uv sphere tessellator
// depends on uvs_pkg and uvs_sinq
//
// usage
//   cfg_wr_en / cfg_wr_data write the segment count; write only while idle
//   input beats carry req_type, ring and column; output beats carry one result
//   a beat moves when valid is high and stall is low on that channel
//   vertex requests give texture coordinates and a unit sphere position,
//   strip requests give the serpentine index pair; bad ranges set range_error
//   one beat per cycle sustained while the output buffer is not full; each
//   beat passes the entry register, 33 step pipelined phase divider, argument
//   register, 22 stage sine pipeline and product register before its result
//   enters the output buffer
//   a two entry output buffer sits after the pipeline; the pipeline freezes
//   only when that buffer is full, so the input keeps moving while one result
//   waits under stall; no beat is lost or repeated
//   reset empties the pipeline and buffer and sets the segment count to 16
module uv_sphere_vertex_and_strip_index #(
  parameter int FRAC_BITS = uvs_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [7:0]         in_ring,
  input  logic [7:0]         in_column,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  output logic signed [15:0] out_pos_z,
  output logic [16:0]        out_tex_u,
  output logic [16:0]        out_tex_v,
  output logic [15:0]        out_first_index,
  output logic [15:0]        out_second_index,
  output logic               out_range_error
);
  import uvs_pkg::*;

  localparam int MW = FRAC_BITS + 1;
  localparam int XZ_W = 2 * FRAC_BITS + 2;

  logic [7:0] seg_r;
  logic       en;
  logic [1:0] cnt_r;
  logic       wp_r;
  logic       rp_r;
  res_t       fifo_r [2];
  logic       push;
  logic       pop;

  // entry
  logic        err_in;
  logic [8:0]  w9;
  logic [7:0]  col;
  logic [15:0] upper;
  logic [15:0] lower;
  meta_t       meta_in;
  div_t        div_in [NUM_DIV];

  logic        vd_r [DIV_STEPS+1];
  meta_t       mt_r [DIV_STEPS+1];
  logic [7:0]  sg_r [DIV_STEPS+1];
  div_t        dv_r [DIV_STEPS+1][NUM_DIV];

  logic [31:0] ph_l;
  logic [31:0] ph_o;
  logic [30:0] arg_r [4];
  logic        vq_r [SINQ_LAT+1];
  meta2_t      dl_r [SINQ_LAT+1];
  logic [MW-1:0] ls;
  logic [MW-1:0] lc;
  logic [MW-1:0] os;
  logic [MW-1:0] oc;

  logic [2*MW+1:0] lmap;
  logic [2*MW+1:0] omap;
  logic [XZ_W-1:0] px_r;
  logic [XZ_W-1:0] pz_r;
  logic [MW-1:0]   ym_r;
  logic            xn_r;
  logic            yn_r;
  logic            zn_r;
  logic            v_m1_r;
  meta2_t          m1_r;

  logic [17:0] xm18;
  logic [17:0] ym18;
  logic [17:0] zm18;
  res_t        res;

  function automatic logic [2*MW+1:0] quad_map(logic [1:0] q, logic [MW-1:0] s,
                                               logic [MW-1:0] c);
    case (q)
      2'd0:    return {1'b0, s, 1'b0, c};
      2'd1:    return {1'b0, c, 1'b1, s};
      2'd2:    return {1'b1, s, 1'b1, c};
      default: return {1'b1, c, 1'b0, s};
    endcase
  endfunction

  function automatic logic [15:0] q15(logic neg, logic [17:0] m);
    logic [17:0] mm;
    if (neg) begin
      mm = (m > 18'd32768) ? 18'd32768 : m;
      return 16'(18'h10000 - mm);
    end else begin
      return (m > 18'd32767) ? 16'h7FFF : 16'(m);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= SEG_RESET;
    end else if (cfg_wr_en) begin
      seg_r <= cfg_wr_data;
    end
  end

  assign en       = (cnt_r != 2'd2);
  assign in_stall = !en;

  always_comb begin
    if (in_req_type == REQ_STRIP) begin
      err_in = (seg_r == 8'd0) || (in_ring >= seg_r) || (in_column > seg_r);
    end else begin
      err_in = (seg_r == 8'd0) || (in_ring > seg_r) || (in_column > seg_r);
    end
    w9    = {1'b0, seg_r} + 9'd1;
    col   = in_ring[0] ? (seg_r - in_column) : in_column;
    upper = 16'(17'(in_ring) * 17'(w9) + 17'(col));
    lower = upper + 16'(w9);
    meta_in.req_type = in_req_type;
    meta_in.err      = err_in;
    meta_in.first    = in_ring[0] ? lower : upper;
    meta_in.second   = in_ring[0] ? upper : lower;
    div_in[0].r = 9'(in_ring[7:1]);
    div_in[0].w = {in_ring[0], 24'd0, seg_r};
    div_in[1].r = 9'(in_column);
    div_in[1].w = {25'd0, seg_r};
    div_in[2].r = 9'd0;
    div_in[2].w = {9'd0, in_column, 9'd0, seg_r[7:1]};
    div_in[3].r = 9'd0;
    div_in[3].w = {9'd0, in_ring, 9'd0, seg_r[7:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mt_r[0] <= meta_in;
      sg_r[0] <= seg_r;
      for (int j = 0; j < NUM_DIV; j++) begin
        dv_r[0][j] <= div_in[j];
      end
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [9:0] st [NUM_DIV];
    logic [8:0] dph;
    logic [8:0] dtx;

    assign dph = {sg_r[k], 1'b0};
    assign dtx = {1'b0, sg_r[k]};

    for (genvar j = 0; j < NUM_DIV; j++) begin : g_lane
      assign st[j] = div_step(dv_r[k][j].r, dv_r[k][j].w[32], (j < 2) ? dph : dtx);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[k+1] <= 1'b0;
      end else if (en) begin
        vd_r[k+1] <= vd_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mt_r[k+1] <= mt_r[k];
        sg_r[k+1] <= sg_r[k];
        for (int j = 0; j < NUM_DIV; j++) begin
          dv_r[k+1][j].r <= st[j][8:0];
          dv_r[k+1][j].w <= {dv_r[k][j].w[31:0], st[j][9]};
        end
      end
    end
  end

  assign ph_l = dv_r[DIV_STEPS][0].w[31:0];
  assign ph_o = dv_r[DIV_STEPS][1].w[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r[0] <= 1'b0;
    end else if (en) begin
      vq_r[0] <= vd_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      arg_r[0]       <= {1'b0, ph_l[29:0]};
      arg_r[1]       <= ONE30 - {1'b0, ph_l[29:0]};
      arg_r[2]       <= {1'b0, ph_o[29:0]};
      arg_r[3]       <= ONE30 - {1'b0, ph_o[29:0]};
      dl_r[0].m      <= mt_r[DIV_STEPS];
      dl_r[0].tex_u  <= dv_r[DIV_STEPS][2].w[16:0];
      dl_r[0].tex_v  <= dv_r[DIV_STEPS][3].w[16:0];
      dl_r[0].ql     <= ph_l[31:30];
      dl_r[0].qo     <= ph_o[31:30];
    end
  end

  for (genvar k = 0; k < SINQ_LAT; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vq_r[k+1] <= 1'b0;
      end else if (en) begin
        vq_r[k+1] <= vq_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dl_r[k+1] <= dl_r[k];
      end
    end
  end

  uvs_sinq #(.FRAC_BITS(FRAC_BITS)) u_sinq_ls (
    .clk(clk), .en(en), .arg(arg_r[0]), .mag(ls)
  );
  uvs_sinq #(.FRAC_BITS(FRAC_BITS)) u_sinq_lc (
    .clk(clk), .en(en), .arg(arg_r[1]), .mag(lc)
  );
  uvs_sinq #(.FRAC_BITS(FRAC_BITS)) u_sinq_os (
    .clk(clk), .en(en), .arg(arg_r[2]), .mag(os)
  );
  uvs_sinq #(.FRAC_BITS(FRAC_BITS)) u_sinq_oc (
    .clk(clk), .en(en), .arg(arg_r[3]), .mag(oc)
  );

  // map {sin sign, sin mag, cos sign, cos mag}
  assign lmap = quad_map(dl_r[SINQ_LAT].ql, ls, lc);
  assign omap = quad_map(dl_r[SINQ_LAT].qo, os, oc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_m1_r <= 1'b0;
    end else if (en) begin
      v_m1_r <= vq_r[SINQ_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= XZ_W'(omap[MW-1:0]) * XZ_W'(lmap[2*MW:MW+1]);
      pz_r <= XZ_W'(omap[2*MW:MW+1]) * XZ_W'(lmap[2*MW:MW+1]);
      ym_r <= lmap[MW-1:0];
      xn_r <= omap[MW] ^ lmap[2*MW+1];
      yn_r <= lmap[MW];
      zn_r <= omap[2*MW+1] ^ lmap[2*MW+1];
      m1_r <= dl_r[SINQ_LAT];
    end
  end

  assign xm18 = 18'((px_r + (XZ_W'(1) << (2 * FRAC_BITS - 16))) >> (2 * FRAC_BITS - 15));
  assign zm18 = 18'((pz_r + (XZ_W'(1) << (2 * FRAC_BITS - 16))) >> (2 * FRAC_BITS - 15));

  if (FRAC_BITS > 15) begin : g_y_round
    assign ym18 = 18'(({1'b0, ym_r} + ((MW+1)'(1) << (FRAC_BITS - 16))) >> (FRAC_BITS - 15));
  end else begin : g_y_shift
    assign ym18 = 18'(ym_r) << (15 - FRAC_BITS);
  end

  always_comb begin
    res = '0;
    if (m1_r.m.err) begin
      res.range_error = 1'b1;
    end else if (m1_r.m.req_type == REQ_STRIP) begin
      res.first_index  = m1_r.m.first;
      res.second_index = m1_r.m.second;
    end else begin
      res.pos_x = q15(xn_r, xm18);
      res.pos_y = q15(yn_r, ym18);
      res.pos_z = q15(zn_r, zm18);
      res.tex_u = m1_r.tex_u;
      res.tex_v = m1_r.tex_v;
    end
  end

  // output buffer
  assign push      = en && v_m1_r;
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_r + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= res;
    end
  end

  assign out_pos_x        = fifo_r[rp_r].pos_x;
  assign out_pos_y        = fifo_r[rp_r].pos_y;
  assign out_pos_z        = fifo_r[rp_r].pos_z;
  assign out_tex_u        = fifo_r[rp_r].tex_u;
  assign out_tex_v        = fifo_r[rp_r].tex_v;
  assign out_first_index  = fifo_r[rp_r].first_index;
  assign out_second_index = fifo_r[rp_r].second_index;
  assign out_range_error  = fifo_r[rp_r].range_error;

endmodule

FILE: bench/uv_sphere_checker.sv
`timescale 1ns / 1ps
// uv_sphere_checker: watches both channels of the uv sphere tessellator,
// predicts each result from the segment count and compares; depends on uvs_pkg
module uv_sphere_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_req_type,
  input  logic [7:0]         in_ring,
  input  logic [7:0]         in_column,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_pos_x,
  input  logic signed [15:0] out_pos_y,
  input  logic signed [15:0] out_pos_z,
  input  logic [16:0]        out_tex_u,
  input  logic [16:0]        out_tex_v,
  input  logic [15:0]        out_first_index,
  input  logic [15:0]        out_second_index,
  input  logic               out_range_error,
  output int                 fail_count,
  output int                 pending
);
  import uvs_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint unsigned Q30 = 64'd1 << 30;

  res_t expected_q[$];
  logic [7:0] seg_count;

  function automatic longint unsigned quarter_sine(longint unsigned a);
    longint unsigned x, x2, t, s;
    longint unsigned dv [6];
    dv = '{156, 110, 72, 42, 20, 6};
    if (a >= Q30) return 64'd1 << FB;
    x = (a * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t = Q30;
    for (int i = 0; i < 6; i++) t = Q30 - ((x2 * t) >> 30) / dv[i];
    s = (x * t) >> 30;
    if (s > Q30) s = Q30;
    return (s + ((64'd1 << (30 - FB)) >> 1)) >> (30 - FB);
  endfunction

  // sign and magnitude of sine and cosine at phase ph
  function automatic void sincos(input logic [31:0] ph, output logic sn,
                                 output longint unsigned sm, output logic cn,
                                 output longint unsigned cm);
    longint unsigned r, s, c;
    r = 64'(ph[29:0]);
    s = quarter_sine(r);
    c = quarter_sine(Q30 - r);
    case (ph[31:30])
      2'd0: begin sn = 1'b0; sm = s; cn = 1'b0; cm = c; end
      2'd1: begin sn = 1'b0; sm = c; cn = 1'b1; cm = s; end
      2'd2: begin sn = 1'b1; sm = s; cn = 1'b1; cm = c; end
      default: begin sn = 1'b1; sm = c; cn = 1'b0; cm = s; end
    endcase
  endfunction

  function automatic logic [31:0] angle_phase(longint unsigned n, longint unsigned s);
    longint unsigned p;
    p = ((n << 32) + s) / (2 * s);
    return p[31:0];
  endfunction

  function automatic logic [15:0] round_q15(logic neg, longint unsigned mag, int fb);
    if (fb > 15) mag = (mag + (64'd1 << (fb - 16))) >> (fb - 15);
    else mag = mag << (15 - fb);
    if (neg) begin
      if (mag > 32768) mag = 32768;
      return 16'((64'h10000 - mag) & 64'hFFFF);
    end
    if (mag > 32767) mag = 32767;
    return 16'(mag);
  endfunction

  function automatic res_t tessellate(logic kind, logic [7:0] ra, logic [7:0] cb,
                                      logic [7:0] sg);
    res_t r;
    longint unsigned s, a, b, w, col, up, lo, lsm, lcm, osm, ocm;
    logic lsn, lcn, osn, ocn;
    r = '0;
    s = 64'(sg); a = 64'(ra); b = 64'(cb);
    if (kind != REQ_STRIP) begin
      if (s == 0 || a > s || b > s) begin
        r.range_error = 1'b1;
        return r;
      end
      sincos(angle_phase(a, s), lsn, lsm, lcn, lcm);
      sincos(angle_phase(2 * b, s), osn, osm, ocn, ocm);
      r.pos_x = round_q15(ocn != lsn, ocm * lsm, 2 * FB);
      r.pos_y = round_q15(lcn, lcm, FB);
      r.pos_z = round_q15(osn != lsn, osm * lsm, 2 * FB);
      r.tex_u = 17'(((b << 16) + s / 2) / s);
      r.tex_v = 17'(((a << 16) + s / 2) / s);
    end else begin
      if (s == 0 || a >= s || b > s) begin
        r.range_error = 1'b1;
        return r;
      end
      w = s + 1;
      col = a[0] ? s - b : b;
      up = a * w + col;
      lo = (a + 1) * w + col;
      r.first_index = 16'(a[0] ? lo : up);
      r.second_index = 16'(a[0] ? up : lo);
    end
    return r;
  endfunction

  always_comb pending = expected_q.size();

  always @(posedge clk) begin
    res_t e;
    if (!rst_n) begin
      seg_count <= SEG_RESET;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (cfg_wr_en) seg_count <= cfg_wr_data;
      if (in_valid && !in_stall)
        expected_q.insert(expected_q.size(),
                          tessellate(in_req_type, in_ring, in_column, seg_count));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%t: unexpected beat, actual %h", $time,
                   {out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v,
                    out_first_index, out_second_index, out_range_error});
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.pos_x !== out_pos_x || e.pos_y !== out_pos_y || e.pos_z !== out_pos_z ||
              e.tex_u !== out_tex_u || e.tex_v !== out_tex_v ||
              e.first_index !== out_first_index || e.second_index !== out_second_index ||
              e.range_error !== out_range_error) begin
            $display("%t: mismatch expected x %0d y %0d z %0d u %0d v %0d f %0d s %0d e %0b",
                     $time, $signed(e.pos_x), $signed(e.pos_y), $signed(e.pos_z), e.tex_u,
                     e.tex_v, e.first_index, e.second_index, e.range_error);
            $display("%t:          actual x %0d y %0d z %0d u %0d v %0d f %0d s %0d e %0b",
                     $time, out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v,
                     out_first_index, out_second_index, out_range_error);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: bench/uv_sphere_vertex_and_strip_index_tb.sv
`timescale 1ns / 1ps
// uv_sphere_vertex_and_strip_index_tb: drives requests and segment counts into
// the tessellator with random gaps and stalls; depends on uvs_pkg and the checker
module uv_sphere_vertex_and_strip_index_tb;
  import uvs_pkg::*;

  localparam int LATENCY = 58;
  localparam int WATCHDOG = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_wr_en = 0;
  logic [7:0] cfg_wr_data = 0;
  logic in_valid = 0;
  logic in_stall;
  logic in_req_type = 0;
  logic [7:0] in_ring = 0;
  logic [7:0] in_column = 0;
  logic out_valid;
  logic out_stall = 1;
  logic signed [15:0] out_pos_x, out_pos_y, out_pos_z;
  logic [16:0] out_tex_u, out_tex_v;
  logic [15:0] out_first_index, out_second_index;
  logic out_range_error;
  int fail_count, pending;
  int idle_cycles = 0;
  int stall_left = 0;
  bit hold_off = 0;
  logic [7:0] seg;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  uv_sphere_vertex_and_strip_index i_dut (.*);

  uv_sphere_checker i_checker (.*);

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
  endfunction

  // receiver stall pattern, with one forced long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1;
      stall_left <= 0;
    end else if (hold_off) begin
      out_stall <= 1;
    end else if (stall_left > 0) begin
      out_stall <= 1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1;
      stall_left <= gap_len();
    end else begin
      out_stall <= 0;
    end
  end

  initial begin
    @(posedge clk);
    wait (rst_n);
    repeat (300) @(posedge clk);
    hold_off <= 1;
    repeat (400) @(posedge clk);
    hold_off <= 0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send(input logic kind, input logic [7:0] a, input logic [7:0] b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_req_type <= kind;
    in_ring <= a;
    in_column <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic set_segments(input logic [7:0] v);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    seg = v;
  endtask

  task automatic directed();
    send(REQ_VERTEX, 8'd0, 8'd0); send(REQ_VERTEX, seg, seg);
    send(REQ_VERTEX, seg / 8'd2, seg / 8'd4);
    send(REQ_VERTEX, seg + 8'd1, 8'd0); send(REQ_VERTEX, 8'd0, seg + 8'd1);
    send(REQ_VERTEX, 8'd255, 8'd255);
    send(REQ_STRIP, 8'd0, 8'd0); send(REQ_STRIP, 8'd1, 8'd0);
    send(REQ_STRIP, seg - 8'd1, seg); send(REQ_STRIP, seg, 8'd0);
    send(REQ_STRIP, 8'd0, seg + 8'd1); send(REQ_STRIP, 8'd255, 8'd255);
    send(REQ_VERTEX, 8'hAA, 8'h55);
  endtask

  task automatic random_phase(input int n);
    logic [7:0] a, b;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        a = 8'($urandom); b = 8'($urandom);
      end else begin
        a = 8'($urandom_range(0, seg));
        b = 8'($urandom_range(0, seg));
      end
      send(($urandom_range(0, 1) == 0) ? REQ_VERTEX : REQ_STRIP, a, b);
    end
  endtask

  initial begin
    logic [7:0] segs_list [7];
    segs_list = '{8'd255, 8'd1, 8'd0, 8'd3, 8'd200, 8'd7, 8'd0};
    seg = SEG_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    directed();
    random_phase(500);
    drain();
    for (int p = 0; p < 7; p++) begin
      set_segments(p == 6 ? 8'($urandom_range(1, 255)) : segs_list[p]);
      directed();
      random_phase(170);
      drain();
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
